// ----- rtl/h_bridge_pwm_kickstart_driver_assert.svh -----
// Assertion helpers used by the checker file.
`ifndef H_BRIDGE_PWM_KICKSTART_DRIVER_ASSERT_SVH
`define H_BRIDGE_PWM_KICKSTART_DRIVER_ASSERT_SVH

// Checked on every clock edge outside reset.
`define HBK_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hbk assertion failed");

// Checked on every clock edge, reset included.
`define HBK_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hbk assertion failed");

`endif

// ----- rtl/hbk_pkg.sv -----
package hbk_pkg;

  localparam int PwmSteps   = 4;
  localparam int KickTicks  = 60;
  localparam int PctFull    = 100;
  localparam int PctHalf    = 50;
  localparam int PctW       = 7;
  localparam int PhaseW     = $clog2(PwmSteps);
  localparam int DutyW      = $clog2(PwmSteps + 1);
  localparam int KickW      = (KickTicks < 2) ? 1 : $clog2(KickTicks + 1);
  localparam int ScaledW    = $clog2(PctFull * PwmSteps + PctHalf + 1);
  localparam int PaddrW     = 2;
  localparam int PdataW     = 32;

  localparam logic [PaddrW-1:0] AddrSpeedPercent = PaddrW'(0);
  localparam logic [PctW-1:0]   SpeedReset       = PctW'(PctFull);

  localparam logic FuncTick = 1'b0;
  localparam logic FuncSet  = 1'b1;

  typedef enum logic [1:0] {
    DirStop  = 2'd0,
    DirFwd   = 2'd1,
    DirRev   = 2'd2,
    DirBrake = 2'd3
  } dir_e;

  typedef struct packed {
    logic       func;
    logic [1:0] direction;
  } req_t;

  typedef struct packed {
    logic       pin_a;
    logic       pin_b;
    logic [1:0] current_direction;
  } rsp_t;

  // Stage handshake between the input register and the core.
  typedef struct packed {
    logic valid;
    req_t req;
  } stage_t;

  // Round pct (saturated at 100) to 0..PwmSteps: count the step thresholds
  // that pct*PwmSteps+50 reaches, each k*100.
  function automatic logic [DutyW-1:0] duty_from_pct(input logic [PctW-1:0] pct);
    logic [PctW-1:0]    sat;
    logic [ScaledW-1:0] scaled;
    logic [DutyW-1:0]   d;
    sat    = (pct > PctW'(PctFull)) ? PctW'(PctFull) : pct;
    scaled = ScaledW'(sat) * ScaledW'(PwmSteps) + ScaledW'(PctHalf);
    d      = '0;
    for (int k = 1; k <= PwmSteps; k++) begin
      if (scaled >= ScaledW'(PctFull * k)) begin
        d = d + DutyW'(1);
      end
    end
    return d;
  endfunction

endpackage

// ----- rtl/h_bridge_pwm_kickstart_driver.sv -----
// H-bridge channel driver with software PWM and a full-power kickstart.
// Request channel (req_valid/req_ready, req): req.func selects a PWM tick
// or a set-direction command; req.direction is stop, forward, reverse or
// brake and only matters for a set. Each request gives exactly one result
// on the rsp channel (rsp_valid/rsp_ready, rsp): both pin levels and the
// direction held after the request.
// A request passes the input register, then the state update into the result
// register; rsp_valid rises once the core takes the request, and a stalled
// result delays that take. One request per cycle is sustained while the
// receiver takes results; the state registers update when a request is taken.
// If the receiver stalls, the result holds and one more request can sit
// in the input register; req_ready drops only when both are full.
// The APB port holds speed_percent at address 0 (reset 100); the derived
// PWM duty is registered from it and follows in the next cycle. Write only while idle.
// Reset (rst, synchronous) empties both registers and returns to stop,
// pins low, no kick pending, phase zero.
module h_bridge_pwm_kickstart_driver (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  hbk_pkg::req_t               req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output hbk_pkg::rsp_t               rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hbk_pkg::PaddrW-1:0]  paddr,
  input  logic [hbk_pkg::PdataW-1:0]  pwdata,
  output logic [hbk_pkg::PdataW-1:0]  prdata,
  output logic                        pready
);

  hbk_pkg::stage_t             stage;
  logic                        take;
  logic [hbk_pkg::DutyW-1:0]   duty;

  hbk_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .duty    (duty)
  );

  hbk_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .take      (take),
    .stage     (stage)
  );

  hbk_core u_core (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .take      (take),
    .duty      (duty),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ----- rtl/hbk_cfg.sv -----
module hbk_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hbk_pkg::PaddrW-1:0]    paddr,
  input  logic [hbk_pkg::PdataW-1:0]    pwdata,
  output logic [hbk_pkg::PdataW-1:0]    prdata,
  output logic                          pready,
  output logic [hbk_pkg::DutyW-1:0]     duty
);

  logic [hbk_pkg::PctW-1:0] speed_percent;
  logic                     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == hbk_pkg::AddrSpeedPercent);

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_percent <= hbk_pkg::SpeedReset;
      duty          <= hbk_pkg::duty_from_pct(hbk_pkg::SpeedReset);
    end else begin
      if (wr_en) begin
        speed_percent <= pwdata[hbk_pkg::PctW-1:0];
      end
      // duty is registered from speed_percent; writing only while idle is left to the user
      duty <= hbk_pkg::duty_from_pct(speed_percent);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == hbk_pkg::AddrSpeedPercent) begin
      prdata = hbk_pkg::PdataW'(speed_percent);
    end
  end

endmodule

// ----- rtl/hbk_in_stage.sv -----
module hbk_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  hbk_pkg::req_t   req,
  input  logic            take,
  output hbk_pkg::stage_t stage
);

  logic          held_valid;
  hbk_pkg::req_t held_req;

  assign req_ready   = !held_valid || take;
  assign stage.valid = held_valid;
  assign stage.req   = held_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (req_ready) begin
      held_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      held_req <= req;
    end
  end

endmodule

// ----- rtl/hbk_core.sv -----
module hbk_core (
  input  logic                      clk,
  input  logic                      rst,
  input  hbk_pkg::stage_t           stage,
  output logic                      take,
  input  logic [hbk_pkg::DutyW-1:0] duty,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output hbk_pkg::rsp_t             rsp
);

  hbk_pkg::dir_e               held_direction, held_direction_next;
  logic [hbk_pkg::KickW-1:0]   kick_remaining, kick_remaining_next;
  logic [hbk_pkg::PhaseW-1:0]  pwm_phase, pwm_phase_next;
  logic                        pin_a, pin_a_next;
  logic                        pin_b, pin_b_next;
  logic                        on;
  logic                        spinning;
  hbk_pkg::dir_e               new_dir;

  assign take     = stage.valid && (!rsp_valid || rsp_ready);
  assign new_dir  = hbk_pkg::dir_e'(stage.req.direction);
  assign spinning = (held_direction == hbk_pkg::DirFwd) ||
                    (held_direction == hbk_pkg::DirRev);

  always_comb begin
    held_direction_next = held_direction;
    kick_remaining_next = kick_remaining;
    pwm_phase_next      = pwm_phase;
    pin_a_next          = pin_a;
    pin_b_next          = pin_b;
    on                  = 1'b0;
    if (stage.req.func == hbk_pkg::FuncSet) begin
      unique case (new_dir)
        hbk_pkg::DirFwd:   begin pin_a_next = 1'b1; pin_b_next = 1'b0; end
        hbk_pkg::DirRev:   begin pin_a_next = 1'b0; pin_b_next = 1'b1; end
        hbk_pkg::DirBrake: begin pin_a_next = 1'b1; pin_b_next = 1'b1; end
        default:           begin pin_a_next = 1'b0; pin_b_next = 1'b0; end
      endcase
      // entering a spin direction from anything else restarts kick and phase
      if ((new_dir == hbk_pkg::DirFwd || new_dir == hbk_pkg::DirRev) &&
          new_dir != held_direction) begin
        kick_remaining_next = hbk_pkg::KickW'(hbk_pkg::KickTicks);
        pwm_phase_next      = '0;
      end
      held_direction_next = new_dir;
    end else if (spinning) begin
      if (kick_remaining != '0) begin
        on                  = 1'b1;
        kick_remaining_next = kick_remaining - hbk_pkg::KickW'(1);
      end else begin
        on = hbk_pkg::DutyW'(pwm_phase) < duty;
      end
      if (held_direction == hbk_pkg::DirFwd) begin
        pin_a_next = on;
      end else begin
        pin_b_next = on;
      end
      if (pwm_phase == hbk_pkg::PhaseW'(hbk_pkg::PwmSteps - 1)) begin
        pwm_phase_next = '0;
      end else begin
        pwm_phase_next = pwm_phase + hbk_pkg::PhaseW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_direction <= hbk_pkg::DirStop;
      kick_remaining <= '0;
      pwm_phase      <= '0;
      pin_a          <= 1'b0;
      pin_b          <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      if (take) begin
        held_direction <= held_direction_next;
        kick_remaining <= kick_remaining_next;
        pwm_phase      <= pwm_phase_next;
        pin_a          <= pin_a_next;
        pin_b          <= pin_b_next;
        rsp_valid      <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp.pin_a             <= pin_a_next;
      rsp.pin_b             <= pin_b_next;
      rsp.current_direction <= held_direction_next;
    end
  end

endmodule

// ----- rtl/hbk_checker.sv -----
`include "h_bridge_pwm_kickstart_driver_assert.svh"

module hbk_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input hbk_pkg::rsp_t rsp
);

  logic pins_ok;

  assign pins_ok =
    (rsp.current_direction == hbk_pkg::DirStop  && !rsp.pin_a && !rsp.pin_b) ||
    (rsp.current_direction == hbk_pkg::DirBrake &&  rsp.pin_a &&  rsp.pin_b) ||
    (rsp.current_direction == hbk_pkg::DirFwd   && !rsp.pin_b) ||
    (rsp.current_direction == hbk_pkg::DirRev   && !rsp.pin_a);

  // stalled result holds
  `HBK_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))

  // nothing comes out the cycle after reset
  `HBK_ASSERT_ALWAYS(a_rsp_reset, clk, rst |=> !rsp_valid)

  // an accepted request shows a result after the input and result registers, or one is already stalled
  `HBK_ASSERT(a_req_to_rsp, clk, rst, req_valid && req_ready |-> ##2 rsp_valid)

  // pins never contradict the held direction
  `HBK_ASSERT(a_pins_dir, clk, rst, rsp_valid |-> pins_ok)

endmodule

bind h_bridge_pwm_kickstart_driver hbk_checker u_hbk_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// ----- tb/tb.sv -----
module tb;
  import hbk_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int PhaseItems    = 100;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_ready;
  req_t                req       = '0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  rsp_t                rsp;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [PaddrW-1:0]   paddr     = '0;
  logic [PdataW-1:0]   pwdata    = '0;
  logic [PdataW-1:0]   prdata;
  logic                pready;

  h_bridge_pwm_kickstart_driver dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // Bridge state as the testbench sees it
  logic [PctW-1:0]   speed_pct  = SpeedReset;
  dir_e              held_dir   = DirStop;
  logic [KickW-1:0]  kick_left  = '0;
  logic [PhaseW-1:0] pwm_pos    = '0;
  logic              lvl_a      = 1'b0;
  logic              lvl_b      = 1'b0;

  req_t pending_cmds[$];
  rsp_t expected_pins[$];

  int   error_count = 0;
  int   idle_cycles = 0;
  logic req_fire    = 1'b0;

  function automatic int quantize_duty(logic [PctW-1:0] pct);
    int p;
    int d;
    p = (int'(pct) > PctFull) ? PctFull : int'(pct);
    d = (p * PwmSteps + PctHalf) / PctFull;
    if (d > PwmSteps) d = PwmSteps;
    return d;
  endfunction

  function automatic rsp_t bridge_step(req_t r);
    rsp_t o;
    logic on;
    dir_e d;
    if (r.func == FuncSet) begin
      d = dir_e'(r.direction);
      case (d)
        DirFwd:   begin lvl_a = 1'b1; lvl_b = 1'b0; end
        DirRev:   begin lvl_a = 1'b0; lvl_b = 1'b1; end
        DirBrake: begin lvl_a = 1'b1; lvl_b = 1'b1; end
        default:  begin lvl_a = 1'b0; lvl_b = 1'b0; d = DirStop; end
      endcase
      // only a change into a spin direction re-arms the kick
      if ((d == DirFwd || d == DirRev) && held_dir != d) begin
        kick_left = KickW'(KickTicks);
        pwm_pos   = '0;
      end
      held_dir = d;
    end else if (held_dir == DirFwd || held_dir == DirRev) begin
      if (kick_left != 0) begin
        on        = 1'b1;
        kick_left = kick_left - 1'b1;
      end else begin
        on = (int'(pwm_pos) < quantize_duty(speed_pct));
      end
      if (held_dir == DirFwd) lvl_a = on;
      else lvl_b = on;
      if (int'(pwm_pos) + 1 >= PwmSteps) pwm_pos = '0;
      else pwm_pos = pwm_pos + 1'b1;
    end
    o.pin_a             = lvl_a;
    o.pin_b             = lvl_b;
    o.current_direction = held_dir;
    return o;
  endfunction

  // request driver: bursts with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    req_t nxt_req;
    logic nxt_valid;
    nxt_req   = req;
    nxt_valid = req_valid;
    if (rst) begin
      nxt_valid = 1'b0;
    end else if (!req_valid || req_fire) begin
      nxt_valid = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending_cmds.size() != 0) begin
        nxt_req   = pending_cmds.pop_front();
        nxt_valid = 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
        end
      end
    end
    req_valid <= nxt_valid;
    req       <= nxt_req;
  end

  // response side stalls
  int   hold_left     = 0;
  int   pattern_left  = 0;
  int   pattern_mode  = 0;
  logic pressure_done = 1'b0;

  always @(negedge clk) begin
    logic nxt;
    if (hold_left != 0) begin
      hold_left--;
      nxt = 1'b0;
    end else if (!pressure_done && pending_cmds.size() > 60) begin
      // long hold so the input side backs up
      hold_left     = 60;
      pressure_done = 1'b1;
      nxt           = 1'b0;
    end else if ($urandom_range(0, 599) == 0) begin
      hold_left = $urandom_range(20, 50);
      nxt       = 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_mode = $urandom_range(0, 3);
        pattern_left = $urandom_range(20, 200);
      end
      pattern_left--;
      case (pattern_mode)
        0:       nxt = 1'b1;
        1:       nxt = 1'($urandom_range(0, 1));
        2:       nxt = (pattern_left % 3 != 0);
        default: nxt = ($urandom_range(0, 7) != 0);
      endcase
    end
    rsp_ready <= nxt;
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    rsp_t want;
    logic rsp_fire;
    if (rst) begin
      req_fire    = 1'b0;
      idle_cycles = 0;
    end else begin
      req_fire = req_valid && req_ready;
      rsp_fire = rsp_valid && rsp_ready;
      if (req_fire) expected_pins.push_back(bridge_step(req));
      if (rsp_fire) begin
        if (expected_pins.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          want = expected_pins.pop_front();
          if (rsp.pin_a !== want.pin_a) begin
            $error("pin_a: expected %0d, got %0d", want.pin_a, rsp.pin_a);
            error_count++;
          end
          if (rsp.pin_b !== want.pin_b) begin
            $error("pin_b: expected %0d, got %0d", want.pin_b, rsp.pin_b);
            error_count++;
          end
          if (rsp.current_direction !== want.current_direction) begin
            $error("current_direction: expected %0d, got %0d",
                   want.current_direction, rsp.current_direction);
            error_count++;
          end
        end
      end
      if (req_fire || rsp_fire) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  task automatic push_cmd(logic func, logic [1:0] dir);
    req_t r;
    r.func      = func;
    r.direction = dir;
    pending_cmds.push_back(r);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || req_valid || expected_pins.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_speed(int pct);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= AddrSpeedPercent;
    pwdata  <= PdataW'(pct);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    speed_pct = PctW'(pct);
    // duty register lags the write
    repeat (2) @(negedge clk);
  endtask

  // mostly spin-up runs, some long enough to get past the kick, some noise
  task automatic queue_random(int n);
    int   count;
    int   ticks;
    logic [1:0] spin;
    count = 0;
    while (count < n) begin
      if ($urandom_range(0, 9) < 7) begin
        spin = $urandom_range(0, 1) ? DirFwd : DirRev;
        push_cmd(FuncSet, spin);
        ticks = $urandom_range(20, 90);
        for (int i = 0; i < ticks; i++) begin
          if ($urandom_range(0, 39) == 0) push_cmd(FuncSet, spin);
          else push_cmd(FuncTick, 2'($urandom_range(0, 3)));
        end
        if ($urandom_range(0, 2) == 0) push_cmd(FuncSet, DirStop);
        count += ticks + 1;
      end else begin
        ticks = $urandom_range(1, 5);
        for (int i = 0; i < ticks; i++) begin
          push_cmd(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
        end
        count += ticks;
      end
    end
  endtask

  int speeds[] = '{0, 127, 12, 13, 37, 38, 62, 63, 87, 88, 101, 50};

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed: idle ticks, brake, stop, repeated and reversed spin
    push_cmd(FuncTick, DirBrake);
    push_cmd(FuncTick, DirStop);
    push_cmd(FuncSet,  DirBrake);
    push_cmd(FuncTick, DirFwd);
    push_cmd(FuncSet,  DirStop);
    push_cmd(FuncTick, DirRev);
    push_cmd(FuncSet,  DirFwd);
    push_cmd(FuncTick, DirBrake);
    push_cmd(FuncTick, DirStop);
    push_cmd(FuncSet,  DirFwd);
    push_cmd(FuncTick, DirRev);
    push_cmd(FuncSet,  DirRev);
    push_cmd(FuncTick, DirFwd);
    push_cmd(FuncSet,  DirRev);
    push_cmd(FuncTick, DirStop);
    push_cmd(FuncSet,  DirBrake);
    push_cmd(FuncTick, DirRev);
    push_cmd(FuncSet,  DirFwd);
    push_cmd(FuncSet,  DirStop);
    push_cmd(FuncTick, DirFwd);
    wait_drained();

    foreach (speeds[i]) begin
      write_speed(speeds[i]);
      queue_random(PhaseItems);
      wait_drained();
    end
    write_speed($urandom_range(0, 127));
    queue_random(PhaseItems);
    wait_drained();
    repeat (10) @(negedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
